// ----- rtl/core/pdms_pkg.sv -----
// shared types and constants for the press duration mode selector
`default_nettype none

package pdms_pkg;

  localparam logic [15:0] HOLD_MAX = 16'hFFFF;
  localparam logic [1:0]  ECON_MAX = 2'd3;

  typedef enum logic [2:0] {
    SIG_NONE   = 3'd0,
    SIG_SERIES = 3'd1,
    SIG_WRITE  = 3'd2,
    SIG_TOGGLE = 3'd3,
    SIG_CLEAR  = 3'd4,
    SIG_HALT   = 3'd5,
    SIG_ECON   = 3'd6
  } sig_t;

  typedef enum logic [3:0] {
    REG_INC_THR    = 4'd0,
    REG_SERIES_THR = 4'd1,
    REG_ECON_THR   = 4'd2,
    REG_HALT_THR   = 4'd3,
    REG_WRFAV_THR  = 4'd4,
    REG_TGFAV_THR  = 4'd5,
    REG_CLRFAV_THR = 4'd6,
    REG_FAV_EN     = 4'd7
  } cfg_reg_t;

endpackage

`default_nettype wire

// ----- rtl/core/press_duration_mode_selector.sv -----
// top level of the press duration mode selector
`default_nettype none

// one-button controller that grades the length of a hold and acts on release
//
// input channel (in_valid/in_ready/pressed): one transfer per button sample
// output channel (out_valid/out_ready/...): one result transfer per sample,
//   carrying the state after that sample was applied
// config port (cfg_we/cfg_index/cfg_data): thresholds and favorites enable;
//   the user writes them only while the block is idle; the block does not enforce it
//
// a result is registered and valid in the cycle after its sample transfer
// throughput: one sample per cycle while results are taken; all grading is a
//   compare ladder between the state registers and the result register
// receiver stall: the result register holds; a new sample is still taken in
//   the cycle that the held result is taken, otherwise in_ready drops
// reset: thresholds return to their defaults, mode and series go to 1,
//   favorites, economy level, hold counter and signal clear, no result pending;
//   the favorite entry store is not cleared and is only read where written
module press_duration_mode_selector
  import pdms_pkg::*;
#(
  parameter int MODE_COUNT           = 8,
  parameter int SERIES_COUNT         = 4,
  parameter int FAV_SLOTS            = 8,
  parameter int RESET_MODE_ON_SERIES = 0
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // sample channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        pressed,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             action_done,
  output logic [2:0]       pending_signal,
  output logic [3:0]       current_mode,
  output logic [2:0]       current_series,
  output logic             fav_active,
  output logic [3:0]       fav_index,
  output logic [3:0]       fav_used,
  output logic [1:0]       economy_level,
  output logic             halt_request,
  output logic [3:0]       fav_entry_mode,
  output logic [2:0]       fav_entry_series,
  output logic             watchdog_kick
);

  // store address width, at least one bit even for a single slot
  localparam int FAV_AW = (FAV_SLOTS > 1) ? $clog2(FAV_SLOTS) : 1;

  // configuration registers
  logic [15:0] inc_threshold;
  logic [15:0] series_threshold;
  logic [15:0] economy_threshold;
  logic [15:0] halt_threshold;
  logic [15:0] write_fav_threshold;
  logic [15:0] toggle_fav_threshold;
  logic [15:0] clear_fav_threshold;
  logic        favorites_enabled;

  // controller state
  logic [15:0] hold_count, hold_count_next, hold_inc;
  logic        last_level;
  logic [3:0]  mode_reg, mode_reg_next;
  logic [2:0]  series_reg, series_reg_next;
  logic        fav_on_reg, fav_on_reg_next;
  logic [3:0]  fav_ptr, fav_ptr_next;
  logic [3:0]  fav_count, fav_count_next;
  logic [1:0]  econ_reg, econ_reg_next;
  sig_t        signal_reg, signal_reg_next;

  // favorite entries, read only at pointers 1 .. fav_count
  logic [3:0]  fav_mode_store   [FAV_SLOTS];
  logic [2:0]  fav_series_store [FAV_SLOTS];

  logic              in_xfer;
  logic              stable, released;
  logic              done, halt, store_we;
  logic [FAV_AW-1:0] rd_idx, wr_idx;
  logic              entry_ok;
  logic [3:0]        entry_mode;
  logic [2:0]        entry_series;

  // result register frees up in the cycle it is taken
  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  assign stable   = (pressed == last_level);
  assign released = !pressed;
  // count pressed samples, saturating
  assign hold_inc = (pressed && hold_count != HOLD_MAX) ? hold_count + 16'd1 : hold_count;
  assign wr_idx   = fav_count[FAV_AW-1:0];

  // config writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      inc_threshold        <= 16'd2;
      series_threshold     <= 16'd100;
      economy_threshold    <= HOLD_MAX;
      halt_threshold       <= HOLD_MAX;
      write_fav_threshold  <= HOLD_MAX;
      toggle_fav_threshold <= HOLD_MAX;
      clear_fav_threshold  <= HOLD_MAX;
      favorites_enabled    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INC_THR:    inc_threshold        <= cfg_data;
        REG_SERIES_THR: series_threshold     <= cfg_data;
        REG_ECON_THR:   economy_threshold    <= cfg_data;
        REG_HALT_THR:   halt_threshold       <= cfg_data;
        REG_WRFAV_THR:  write_fav_threshold  <= cfg_data;
        REG_TGFAV_THR:  toggle_fav_threshold <= cfg_data;
        REG_CLRFAV_THR: clear_fav_threshold  <= cfg_data;
        REG_FAV_EN:     favorites_enabled    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // grading ladder: first threshold exceeded wins, action on stable release
  always_comb begin
    hold_count_next = hold_inc;
    mode_reg_next   = mode_reg;
    series_reg_next = series_reg;
    fav_on_reg_next = fav_on_reg;
    fav_ptr_next    = fav_ptr;
    fav_count_next  = fav_count;
    econ_reg_next   = econ_reg;
    signal_reg_next = signal_reg;
    done            = 1'b0;
    halt            = 1'b0;
    store_we        = 1'b0;
    if (stable) begin
      if (hold_inc > clear_fav_threshold) begin
        signal_reg_next = SIG_CLEAR;
        if (released) begin
          fav_ptr_next    = 4'd0;
          fav_count_next  = 4'd0;
          fav_on_reg_next = 1'b0;
          signal_reg_next = SIG_NONE;
          done            = 1'b1;
        end
      end else if (hold_inc > toggle_fav_threshold) begin
        signal_reg_next = SIG_TOGGLE;
        if (released) begin
          if (!fav_on_reg) begin
            fav_on_reg_next = 1'b1;
            fav_ptr_next    = 4'd1;
          end else begin
            fav_on_reg_next = 1'b0;
          end
          signal_reg_next = SIG_NONE;
          done            = 1'b1;
        end
      end else if (hold_inc > write_fav_threshold) begin
        // level taken even when blocked; lower levels are not looked at
        if (!fav_on_reg && fav_count < 4'(FAV_SLOTS)) begin
          signal_reg_next = SIG_WRITE;
          if (released) begin
            store_we        = 1'b1;
            fav_count_next  = fav_count + 4'd1;
            signal_reg_next = SIG_NONE;
            done            = 1'b1;
          end
        end
      end else if (hold_inc > halt_threshold) begin
        signal_reg_next = SIG_HALT;
        if (released) begin
          halt            = 1'b1;
          signal_reg_next = SIG_NONE;
          done            = 1'b1;
        end
      end else if (hold_inc > economy_threshold) begin
        signal_reg_next = SIG_ECON;
        if (released) begin
          econ_reg_next   = (econ_reg >= ECON_MAX) ? 2'd0 : econ_reg + 2'd1;
          signal_reg_next = SIG_NONE;
          done            = 1'b1;
        end
      end else if (hold_inc > series_threshold) begin
        if (!favorites_enabled || !fav_on_reg) begin
          signal_reg_next = SIG_SERIES;
          if (released) begin
            series_reg_next = (series_reg >= 3'(SERIES_COUNT)) ? 3'd1 : series_reg + 3'd1;
            if (RESET_MODE_ON_SERIES != 0) begin
              mode_reg_next = 4'd1;
            end
            signal_reg_next = SIG_NONE;
            done            = 1'b1;
          end
        end
      end else if (hold_inc > inc_threshold) begin
        // next mode keeps the pending signal as it is
        if (released) begin
          if (favorites_enabled && fav_on_reg) begin
            fav_ptr_next = (fav_ptr >= fav_count) ? 4'd1 : fav_ptr + 4'd1;
          end else begin
            mode_reg_next = (mode_reg >= 4'(MODE_COUNT)) ? 4'd1 : mode_reg + 4'd1;
          end
          done = 1'b1;
        end
      end
    end
    // two released samples in a row end the hold
    if (!pressed && !last_level) begin
      hold_count_next = 16'd0;
    end
  end

  // entry at the updated pointer, forwarding a write made by this sample
  always_comb begin
    rd_idx       = FAV_AW'(fav_ptr_next - 4'd1);
    entry_ok     = (fav_ptr_next != 4'd0) && (fav_ptr_next <= fav_count_next);
    entry_mode   = 4'd0;
    entry_series = 3'd0;
    if (entry_ok) begin
      if (store_we && rd_idx == wr_idx) begin
        entry_mode   = mode_reg;
        entry_series = series_reg;
      end else begin
        entry_mode   = fav_mode_store[rd_idx];
        entry_series = fav_series_store[rd_idx];
      end
    end
  end

  // state update, one sample per transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_count <= 16'd0;
      last_level <= 1'b0;
      mode_reg   <= 4'd1;
      series_reg <= 3'd1;
      fav_on_reg <= 1'b0;
      fav_ptr    <= 4'd0;
      fav_count  <= 4'd0;
      econ_reg   <= 2'd0;
      signal_reg <= SIG_NONE;
    end else if (in_xfer) begin
      hold_count <= hold_count_next;
      last_level <= pressed;
      mode_reg   <= mode_reg_next;
      series_reg <= series_reg_next;
      fav_on_reg <= fav_on_reg_next;
      fav_ptr    <= fav_ptr_next;
      fav_count  <= fav_count_next;
      econ_reg   <= econ_reg_next;
      signal_reg <= signal_reg_next;
    end
  end

  // favorite entry store, no reset
  always_ff @(posedge clk) begin
    if (in_xfer && store_we) begin
      fav_mode_store[wr_idx]   <= mode_reg;
      fav_series_store[wr_idx] <= series_reg;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      action_done      <= done;
      pending_signal   <= signal_reg_next;
      current_mode     <= mode_reg_next;
      current_series   <= series_reg_next;
      fav_active       <= fav_on_reg_next;
      fav_index        <= fav_ptr_next;
      fav_used         <= fav_count_next;
      economy_level    <= econ_reg_next;
      halt_request     <= halt;
      fav_entry_mode   <= entry_mode;
      fav_entry_series <= entry_series;
      watchdog_kick    <= stable;
    end
  end

`ifndef SYNTHESIS
  a_halt_is_action: assert property (@(posedge clk) disable iff (rst)
    out_valid && halt_request |-> action_done)
    else $error("halt request without action");

  a_action_needs_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && action_done |-> watchdog_kick)
    else $error("action on an unstable sample");

  a_fav_count_bound: assert property (@(posedge clk) disable iff (rst)
    fav_count <= 4'(FAV_SLOTS))
    else $error("favorite count beyond slots");

  a_hold_cleared: assert property (@(posedge clk) disable iff (rst)
    in_xfer && !pressed && !last_level |=> hold_count == 16'd0)
    else $error("hold counter not cleared after release");

  a_hold_saturates: assert property (@(posedge clk) disable iff (rst)
    in_xfer && pressed && hold_count == HOLD_MAX |=> hold_count == HOLD_MAX)
    else $error("hold counter wrapped");
`endif

endmodule

`default_nettype wire

// ----- verif/press_duration_mode_selector_test.sv -----
// self-checking testbench for the press duration mode selector
`timescale 1ns / 1ps

module press_duration_mode_selector_test;
  import pdms_pkg::*;

  // block build, kept at its defaults
  localparam int MODE_COUNT           = 8;
  localparam int SERIES_COUNT         = 4;
  localparam int FAV_SLOTS            = 8;
  localparam int RESET_MODE_ON_SERIES = 0;

  localparam int IDLE_PCT     = 17;       // chance in a hundred that a side idles
  localparam int RANDOM_TICKS = 1950;     // random samples before the run winds down
  localparam int PHASE_TICKS  = 200;      // least samples fed in each random settings phase
  localparam int CYCLE_LIMIT  = 100_000;  // watchdog limit in clock cycles for the whole run
  localparam int SHOW_LIMIT   = 30;       // mismatch lines printed before going quiet

  // everything the block shows after one sample
  typedef struct {
    logic       action;
    sig_t       signal;
    logic [3:0] mode;
    logic [2:0] series;
    logic       fav_on;
    logic [3:0] cursor;
    logic [3:0] stored;
    logic [1:0] econ;
    logic       halt;
    logic [3:0] entry_mode;
    logic [2:0] entry_series;
    logic       kick;
  } tick_result_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [3:0]  cfg_index = REG_INC_THR;
  logic [15:0] cfg_data  = 16'd0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic        pressed   = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        action_done;
  logic [2:0]  pending_signal;
  logic [3:0]  current_mode;
  logic [2:0]  current_series;
  logic        fav_active;
  logic [3:0]  fav_index;
  logic [3:0]  fav_used;
  logic [1:0]  economy_level;
  logic        halt_request;
  logic [3:0]  fav_entry_mode;
  logic [2:0]  fav_entry_series;
  logic        watchdog_kick;

  press_duration_mode_selector #(
    .MODE_COUNT          (MODE_COUNT),
    .SERIES_COUNT        (SERIES_COUNT),
    .FAV_SLOTS           (FAV_SLOTS),
    .RESET_MODE_ON_SERIES(RESET_MODE_ON_SERIES)
  ) dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .pressed         (pressed),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .action_done     (action_done),
    .pending_signal  (pending_signal),
    .current_mode    (current_mode),
    .current_series  (current_series),
    .fav_active      (fav_active),
    .fav_index       (fav_index),
    .fav_used        (fav_used),
    .economy_level   (economy_level),
    .halt_request    (halt_request),
    .fav_entry_mode  (fav_entry_mode),
    .fav_entry_series(fav_entry_series),
    .watchdog_kick   (watchdog_kick)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor state, starting from the reset values
  // ---------------------------------------------------------------------------

  // thresholds indexed by register index, then the favorites enable
  logic [15:0] level_thr [REG_CLRFAV_THR+1] =
    '{16'd2, 16'd100, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
  logic        fav_enable = 1'b0;

  logic [15:0] hold_ticks   = 16'd0;
  logic        prev_level   = 1'b0;
  logic [3:0]  sel_mode     = 4'd1;
  logic [2:0]  sel_series   = 3'd1;
  logic        fav_mode_on  = 1'b0;
  logic [3:0]  fav_cursor   = 4'd0;
  logic [3:0]  fav_stored   = 4'd0;
  logic [1:0]  econ_step    = 2'd0;
  sig_t        shown_signal = SIG_NONE;
  logic [3:0]  fav_mode_mem   [FAV_SLOTS];
  logic [2:0]  fav_series_mem [FAV_SLOTS];

  // stimulus and scoreboard
  logic         level_feed [$];      // samples waiting for the driver
  tick_result_t expected_ticks [$];  // predicted results, oldest first
  int           ticks_fed    = 0;
  int           ticks_taken  = 0;
  int           random_fed   = 0;
  int           error_count  = 0;
  int           cycle_count  = 0;
  bit           steady       = 1'b0;  // no idling on either side while set
  logic         in_taken     = 1'b0;  // sample transfer at the last rising edge

  // one sample: count the hold, grade it on stable ticks, act on stable release
  function automatic tick_result_t advance_tick(input logic level);
    tick_result_t res;
    logic         stable;
    logic         released;
    logic [15:0]  h;
    res.action = 1'b0;
    res.halt   = 1'b0;
    stable     = (level == prev_level);
    released   = !level;
    if (level && hold_ticks != HOLD_MAX) hold_ticks++;
    h = hold_ticks;
    if (stable) begin
      // ladder from the longest hold down, first exceeded threshold wins
      if (h > level_thr[REG_CLRFAV_THR]) begin
        shown_signal = SIG_CLEAR;
        if (released) begin
          fav_cursor   = 4'd0;
          fav_stored   = 4'd0;
          fav_mode_on  = 1'b0;
          shown_signal = SIG_NONE;
          res.action   = 1'b1;
        end
      end else if (h > level_thr[REG_TGFAV_THR]) begin
        shown_signal = SIG_TOGGLE;
        if (released) begin
          // turning favorite mode on points at the first entry
          if (!fav_mode_on) fav_cursor = 4'd1;
          fav_mode_on  = !fav_mode_on;
          shown_signal = SIG_NONE;
          res.action   = 1'b1;
        end
      end else if (h > level_thr[REG_WRFAV_THR]) begin
        // level still taken when blocked, but keeps the shown signal and does nothing
        if (!fav_mode_on && fav_stored < FAV_SLOTS) begin
          shown_signal = SIG_WRITE;
          if (released) begin
            fav_mode_mem[fav_stored]   = sel_mode;
            fav_series_mem[fav_stored] = sel_series;
            fav_stored++;
            shown_signal = SIG_NONE;
            res.action   = 1'b1;
          end
        end
      end else if (h > level_thr[REG_HALT_THR]) begin
        shown_signal = SIG_HALT;
        if (released) begin
          res.halt     = 1'b1;
          shown_signal = SIG_NONE;
          res.action   = 1'b1;
        end
      end else if (h > level_thr[REG_ECON_THR]) begin
        shown_signal = SIG_ECON;
        if (released) begin
          econ_step    = (econ_step >= ECON_MAX) ? 2'd0 : econ_step + 2'd1;
          shown_signal = SIG_NONE;
          res.action   = 1'b1;
        end
      end else if (h > level_thr[REG_SERIES_THR]) begin
        // in favorite mode with favorites enabled the series level is inert
        if (!fav_enable || !fav_mode_on) begin
          shown_signal = SIG_SERIES;
          if (released) begin
            sel_series = (sel_series >= SERIES_COUNT) ? 3'd1 : sel_series + 3'd1;
            if (RESET_MODE_ON_SERIES != 0) sel_mode = 4'd1;
            shown_signal = SIG_NONE;
            res.action   = 1'b1;
          end
        end
      end else if (h > level_thr[REG_INC_THR]) begin
        // mode step leaves the shown signal alone
        if (released) begin
          if (fav_enable && fav_mode_on)
            fav_cursor = (fav_cursor >= fav_stored) ? 4'd1 : fav_cursor + 4'd1;
          else
            sel_mode = (sel_mode >= MODE_COUNT) ? 4'd1 : sel_mode + 4'd1;
          res.action = 1'b1;
        end
      end
    end
    if (!level && !prev_level) hold_ticks = 16'd0;
    prev_level = level;

    res.signal = shown_signal;
    res.mode   = sel_mode;
    res.series = sel_series;
    res.fav_on = fav_mode_on;
    res.cursor = fav_cursor;
    res.stored = fav_stored;
    res.econ   = econ_step;
    res.kick   = stable;
    // entry outputs read only written slots
    if (fav_cursor >= 4'd1 && fav_cursor <= fav_stored) begin
      res.entry_mode   = fav_mode_mem[fav_cursor - 4'd1];
      res.entry_series = fav_series_mem[fav_cursor - 4'd1];
    end else begin
      res.entry_mode   = 4'd0;
      res.entry_series = 3'd0;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= SHOW_LIMIT)
      $display("press_duration_mode_selector_test: %0t ns: %s", $realtime, msg);
  endtask

  task automatic check_field(input string field, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_error($sformatf("%s is %0h, expected %0h (result %0d)",
                             field, got, want, ticks_taken - expected_ticks.size()));
  endtask

  task automatic check_result();
    tick_result_t want;
    if (expected_ticks.size() == 0) begin
      report_error("result transfer with no sample waiting");
      return;
    end
    want = expected_ticks.pop_front();
    check_field("action_done",      action_done,      want.action);
    check_field("pending_signal",   pending_signal,   want.signal);
    check_field("current_mode",     current_mode,     want.mode);
    check_field("current_series",   current_series,   want.series);
    check_field("fav_active",       fav_active,       want.fav_on);
    check_field("fav_index",        fav_index,        want.cursor);
    check_field("fav_used",         fav_used,         want.stored);
    check_field("economy_level",    economy_level,    want.econ);
    check_field("halt_request",     halt_request,     want.halt);
    check_field("fav_entry_mode",   fav_entry_mode,   want.entry_mode);
    check_field("fav_entry_series", fav_entry_series, want.entry_series);
    check_field("watchdog_kick",    watchdog_kick,    want.kick);
  endtask

  // ---------------------------------------------------------------------------
  // driver: inputs move on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      // valid holds with the same sample until its transfer
      if (!in_valid || in_taken) begin
        if (level_feed.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          pressed  <= level_feed.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: both channels sampled on the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      // results trail their sample through the result register, so check before predicting
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) begin
        expected_ticks.push_back(advance_tick(pressed));
        ticks_taken++;
      end
    end
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("press_duration_mode_selector_test: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void feed(input logic level);
    level_feed.push_back(level);
    ticks_fed++;
  endfunction

  // press for some ticks, then let go for some ticks
  function automatic void push_press(input int held, input int rest);
    repeat (held) feed(1'b1);
    repeat (rest) feed(1'b0);
  endfunction

  // every sample transferred and every result back
  task automatic wait_idle();
    while (ticks_taken != ticks_fed || expected_ticks.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // config write on the falling edge, one cycle wide
  task automatic write_reg(input logic [3:0] index, input logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (index <= REG_CLRFAV_THR) level_thr[index] = value;
    else if (index == REG_FAV_EN) fav_enable = value[0];
  endtask

  task automatic write_thresholds(input logic [15:0] plan [REG_CLRFAV_THR+1]);
    for (int r = REG_INC_THR; r <= REG_CLRFAV_THR; r++) write_reg(4'(r), plan[r]);
  endtask

  // one settings phase with random holds; spread gives an unordered ladder
  task automatic random_phase(input bit spread);
    logic [15:0] plan [REG_CLRFAV_THR+1];
    int          start;
    int          k;
    int          held;
    int          rest;
    if (spread) begin
      for (int r = REG_INC_THR; r <= REG_CLRFAV_THR; r++) plan[r] = $urandom_range(12);
    end else begin
      // short ladder rising from mode step to clear, so every level is in reach of a short hold
      plan[REG_INC_THR] = $urandom_range(3);
      for (int r = REG_SERIES_THR; r <= REG_CLRFAV_THR; r++)
        plan[r] = plan[r-1] + $urandom_range(1, 3);
    end
    // now and then a level is switched off
    for (int r = REG_ECON_THR; r <= REG_CLRFAV_THR; r++)
      if ($urandom_range(4) == 0) plan[r] = HOLD_MAX;
    write_thresholds(plan);
    // upper bits of the enable data must be dropped
    write_reg(REG_FAV_EN, 16'($urandom));
    // writes past the register list must change nothing
    write_reg(4'(REG_FAV_EN + $urandom_range(1, 8)), 16'($urandom));

    start = ticks_fed;
    while (ticks_fed - start < PHASE_TICKS) begin
      if ($urandom_range(7) == 0) begin
        // noise: bounces and runs of random levels
        repeat ($urandom_range(1, 6)) feed(1'($urandom));
      end else begin
        // aim most holds at a threshold, just at it or just past it
        k = $urandom_range(REG_INC_THR, REG_CLRFAV_THR);
        if ($urandom_range(9) < 8 && level_thr[k] < 16'd60)
          held = level_thr[k] + $urandom_range(0, 2);
        else
          held = $urandom_range(1, 20);
        if (held == 0) held = 1;
        // a single released tick lets the next press extend the hold
        rest = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 4);
        push_press(held, rest);
      end
    end
    random_fed += ticks_fed - start;
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [15:0] plan [REG_CLRFAV_THR+1];
    int          phase;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: mode step past 2 ticks, series past 100
    push_press(1, 2);           // under every threshold
    push_press(2, 2);           // exactly at the mode threshold, no step
    push_press(3, 2);           // mode step
    feed(1'b1); feed(1'b0);     // bounce: hold survives the unstable release
    feed(1'b1); feed(1'b1);
    feed(1'b0); feed(1'b0);
    wait_idle();

    // lowest settings: every threshold 0, favorites on, so any hold clears
    for (int r = REG_INC_THR; r <= REG_CLRFAV_THR; r++) plan[r] = 16'd0;
    write_thresholds(plan);
    write_reg(REG_FAV_EN, 16'd1);
    push_press(1, 2);
    push_press(2, 3);
    wait_idle();

    // top settings: the upper levels sit at or just under the counter limit
    // and stay out of reach, so short holds fall through to halt and economy
    plan[REG_INC_THR]    = 16'd0;
    plan[REG_SERIES_THR] = 16'd1;
    plan[REG_ECON_THR]   = 16'd2;
    plan[REG_HALT_THR]   = 16'd3;
    plan[REG_WRFAV_THR]  = HOLD_MAX - 16'd2;
    plan[REG_TGFAV_THR]  = HOLD_MAX;
    plan[REG_CLRFAV_THR] = HOLD_MAX - 16'd1;
    write_thresholds(plan);
    write_reg(REG_FAV_EN, 16'hFFFE);
    push_press(4, 2);           // halt level
    push_press(3, 2);           // economy level
    wait_idle();

    // random phases; the second one runs with no idling at all
    phase = 0;
    while (random_fed < RANDOM_TICKS) begin
      steady = (phase == 1);
      random_phase(phase % 3 == 2);
      phase++;
    end
    steady = 1'b0;

    wait_idle();
    repeat (4) @(posedge clk);
    if (expected_ticks.size() != 0) report_error("results never delivered");
    if (error_count == 0) begin
      $display("press_duration_mode_selector_test: done, clean");
    end else begin
      $display("press_duration_mode_selector_test: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/pdms_pkg.sv
rtl/core/press_duration_mode_selector.sv
verif/press_duration_mode_selector_test.sv
